// File: rtl/slci_pkg.sv
// Shared constants, control types and text tables of the serial LED command interpreter.
package slci_pkg;

  // Line buffer depth and the widths that follow from it, plus the index and text widths.
  localparam int LINE_MAX = 10;
  localparam int CNT_W    = $clog2(LINE_MAX + 1);
  localparam int ADDR_W   = $clog2(LINE_MAX);
  localparam int CMD_IDX_W = 5;
  localparam int MSG_IDX_W = 4;
  localparam int TEXT_W    = 128;

  // Special characters.
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  // Command codes.
  localparam logic [1:0] CMD_ON1  = 2'd0;
  localparam logic [1:0] CMD_OFF1 = 2'd1;
  localparam logic [1:0] CMD_ON2  = 2'd2;
  localparam logic [1:0] CMD_OFF2 = 2'd3;

  // Reply message codes.
  localparam logic [2:0] MSG_LONG = 3'd0;
  localparam logic [2:0] MSG_BAD  = 3'd1;
  localparam logic [2:0] MSG_ON1  = 3'd2;
  localparam logic [2:0] MSG_OFF1 = 3'd3;
  localparam logic [2:0] MSG_ON2  = 3'd4;
  localparam logic [2:0] MSG_OFF2 = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_byte;
    logic start_long;
    logic start_scan;
    logic scan_step;
    logic finish_scan;
    logic echo_step;
    logic reply_step;
    logic echo_sel;
  } slci_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rx_is_cr;
    logic rx_is_lf;
    logic line_full;
    logic scan_done;
    logic scan_empty;
    logic echo_last;
    logic reply_last;
  } slci_stat_t;

  // Length of a command string.
  function automatic logic [CMD_IDX_W-1:0] cmd_len(input logic [1:0] c);
    logic [CMD_IDX_W-1:0] len;
    case (c)
      CMD_ON1:  len = CMD_IDX_W'(7);
      CMD_OFF1: len = CMD_IDX_W'(8);
      CMD_ON2:  len = CMD_IDX_W'(7);
      CMD_OFF2: len = CMD_IDX_W'(8);
      default:  len = CMD_IDX_W'(7);
    endcase
    return len;
  endfunction

  // Character of a command string; zero past its end.
  function automatic logic [7:0] cmd_char(input logic [1:0] c,
                                          input logic [CMD_IDX_W-1:0] i);
    logic [TEXT_W-1:0] text;
    logic [CMD_IDX_W-1:0] len;
    logic [7:0] ch;
    len = cmd_len(c);
    case (c)
      CMD_ON1:  text = TEXT_W'("ledon 1");
      CMD_OFF1: text = TEXT_W'("ledoff 1");
      CMD_ON2:  text = TEXT_W'("ledon 2");
      CMD_OFF2: text = TEXT_W'("ledoff 2");
      default:  text = '0;
    endcase
    if (i >= len) begin
      ch = CH_NUL;
    end else begin
      ch = 8'(text >> (8 * (int'(len) - 1 - int'(i))));
    end
    return ch;
  endfunction

  // Length of a reply message.
  function automatic logic [MSG_IDX_W:0] msg_len(input logic [2:0] m);
    logic [MSG_IDX_W:0] len;
    case (m)
      MSG_LONG: len = (MSG_IDX_W + 1)'(16);
      MSG_BAD:  len = (MSG_IDX_W + 1)'(16);
      MSG_ON1:  len = (MSG_IDX_W + 1)'(10);
      MSG_OFF1: len = (MSG_IDX_W + 1)'(11);
      MSG_ON2:  len = (MSG_IDX_W + 1)'(10);
      MSG_OFF2: len = (MSG_IDX_W + 1)'(11);
      default:  len = (MSG_IDX_W + 1)'(16);
    endcase
    return len;
  endfunction

  // Character of a reply message; the carriage return is written in octal.
  function automatic logic [7:0] msg_char(input logic [2:0] m,
                                          input logic [MSG_IDX_W-1:0] i);
    logic [TEXT_W-1:0] text;
    logic [MSG_IDX_W:0] len;
    len = msg_len(m);
    case (m)
      MSG_LONG: text = TEXT_W'("Input Too Long\015\n");
      MSG_BAD:  text = TEXT_W'("Incorrect prompt");
      MSG_ON1:  text = TEXT_W'("LED1 ON.\015\n");
      MSG_OFF1: text = TEXT_W'("LED1 OFF.\015\n");
      MSG_ON2:  text = TEXT_W'("LED2 ON.\015\n");
      MSG_OFF2: text = TEXT_W'("LED2 OFF.\015\n");
      default:  text = '0;
    endcase
    return 8'(text >> (8 * (int'(len) - 1 - int'(i))));
  endfunction

endpackage

// File: rtl/slci_datapath.sv
// Datapath: line buffer, scan and echo counters, command match flags, LEDs and reply text.
module slci_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          rx_byte_i,
  input  slci_pkg::slci_cmd_t cmd_i,
  output slci_pkg::slci_stat_t stat_o,
  output logic [7:0]          tx_byte_o,
  output logic                last_of_run_o,
  output logic                led_one_on_o,
  output logic                led_two_on_o
);
  import slci_pkg::*;

  logic [7:0]           line_store_q [LINE_MAX];
  logic [CNT_W-1:0]     line_len_q, line_len_d;
  logic [CNT_W-1:0]     pos_q, pos_d;
  logic [CNT_W-1:0]     echo_len_q, echo_len_d;
  logic [MSG_IDX_W-1:0] msg_pos_q, msg_pos_d;
  logic [2:0]           msg_sel_q, msg_sel_d;
  logic [3:0]           match_q, match_d;
  logic                 led_one_q, led_one_d;
  logic                 led_two_q, led_two_d;
  logic [7:0]           cur_ch;
  logic [3:0]           hit;
  logic                 reply_last;

  // Character under the scan and echo pointer.
  assign cur_ch = line_store_q[pos_q[ADDR_W-1:0]];

  // Final match of each command: every compared character equal and the length exact.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      hit[c] = match_q[c] && (CMD_IDX_W'(pos_q) == cmd_len(2'(c)));
    end
  end

  assign reply_last = ({1'b0, msg_pos_q} == (msg_len(msg_sel_q) - (MSG_IDX_W + 1)'(1)));

  // Status toward the controller.
  always_comb begin
    stat_o.rx_is_cr   = (rx_byte_i == CH_CR);
    stat_o.rx_is_lf   = (rx_byte_i == CH_LF);
    stat_o.line_full  = (line_len_q == CNT_W'(LINE_MAX));
    stat_o.scan_done  = (pos_q == line_len_q) || (cur_ch == CH_NUL);
    stat_o.scan_empty = (pos_q == '0);
    stat_o.echo_last  = ((pos_q + CNT_W'(1)) == echo_len_q);
    stat_o.reply_last = reply_last;
  end

  // Next-state logic of counters, flags and LEDs.
  always_comb begin
    line_len_d = line_len_q;
    pos_d      = pos_q;
    echo_len_d = echo_len_q;
    msg_pos_d  = msg_pos_q;
    msg_sel_d  = msg_sel_q;
    match_d    = match_q;
    led_one_d  = led_one_q;
    led_two_d  = led_two_q;
    if (cmd_i.store_byte) begin
      line_len_d = line_len_q + CNT_W'(1);
    end
    if (cmd_i.start_long) begin
      line_len_d = '0;
      msg_sel_d  = MSG_LONG;
      msg_pos_d  = '0;
    end
    if (cmd_i.start_scan) begin
      pos_d   = '0;
      match_d = '1;
    end
    if (cmd_i.scan_step) begin
      for (int c = 0; c < 4; c++) begin
        match_d[c] = match_q[c] && (cmd_char(2'(c), CMD_IDX_W'(pos_q)) == cur_ch);
      end
      pos_d = pos_q + CNT_W'(1);
    end
    if (cmd_i.finish_scan) begin
      line_len_d = '0;
      echo_len_d = pos_q;
      pos_d      = '0;
      msg_pos_d  = '0;
      if (hit[CMD_ON1]) begin
        led_one_d = 1'b1;
        msg_sel_d = MSG_ON1;
      end else if (hit[CMD_OFF1]) begin
        led_one_d = 1'b0;
        msg_sel_d = MSG_OFF1;
      end else if (hit[CMD_ON2]) begin
        led_two_d = 1'b1;
        msg_sel_d = MSG_ON2;
      end else if (hit[CMD_OFF2]) begin
        led_two_d = 1'b0;
        msg_sel_d = MSG_OFF2;
      end else begin
        msg_sel_d = MSG_BAD;
      end
    end
    if (cmd_i.echo_step) begin
      pos_d = pos_q + CNT_W'(1);
    end
    if (cmd_i.reply_step) begin
      msg_pos_d = msg_pos_q + MSG_IDX_W'(1);
    end
  end

  // Control and status registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q <= '0;
      pos_q      <= '0;
      echo_len_q <= '0;
      msg_pos_q  <= '0;
      msg_sel_q  <= MSG_BAD;
      match_q    <= '0;
      led_one_q  <= 1'b0;
      led_two_q  <= 1'b0;
    end else begin
      line_len_q <= line_len_d;
      pos_q      <= pos_d;
      echo_len_q <= echo_len_d;
      msg_pos_q  <= msg_pos_d;
      msg_sel_q  <= msg_sel_d;
      match_q    <= match_d;
      led_one_q  <= led_one_d;
      led_two_q  <= led_two_d;
    end
  end

  // Line buffer write; the contents need no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte) begin
      line_store_q[line_len_q[ADDR_W-1:0]] <= rx_byte_i;
    end
  end

  // Output payload: echoed text or reply text.
  assign tx_byte_o     = cmd_i.echo_sel ? cur_ch : msg_char(msg_sel_q, msg_pos_q);
  assign last_of_run_o = !cmd_i.echo_sel && reply_last;
  assign led_one_on_o  = led_one_q;
  assign led_two_on_o  = led_two_q;

endmodule

// File: rtl/slci_controller.sv
// Controller: state machine that sequences storing, scanning, echo and reply.
module slci_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rx_valid_i,
  output logic                 rx_stall_o,
  output logic                 tx_valid_o,
  input  logic                 tx_stall_i,
  input  slci_pkg::slci_stat_t stat_i,
  output slci_pkg::slci_cmd_t  cmd_o
);
  import slci_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_ECHO  = 2'd2;
  localparam logic [1:0] ST_REPLY = 2'd3;

  logic [1:0] state_q, state_d;
  logic       tx_take;

  assign rx_stall_o = (state_q != ST_IDLE);
  assign tx_valid_o = (state_q == ST_ECHO) || (state_q == ST_REPLY);
  assign tx_take    = tx_valid_o && !tx_stall_i;

  // Transition and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.echo_sel = (state_q == ST_ECHO);
    case (state_q)
      ST_IDLE: begin
        if (rx_valid_i && !stat_i.rx_is_lf) begin
          if (stat_i.rx_is_cr) begin
            cmd_o.start_scan = 1'b1;
            state_d = ST_SCAN;
          end else if (!stat_i.line_full) begin
            cmd_o.store_byte = 1'b1;
          end else begin
            cmd_o.start_long = 1'b1;
            state_d = ST_REPLY;
          end
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_done) begin
          cmd_o.finish_scan = 1'b1;
          state_d = stat_i.scan_empty ? ST_REPLY : ST_ECHO;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_ECHO: begin
        if (tx_take) begin
          cmd_o.echo_step = 1'b1;
          if (stat_i.echo_last) begin
            state_d = ST_REPLY;
          end
        end
      end
      ST_REPLY: begin
        if (tx_take) begin
          if (stat_i.reply_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.reply_step = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/serial_led_command_interpreter_unit.sv
// Top level of the serial LED command interpreter: controller, datapath and checks.
// An ordinary byte or a line feed is taken and the block is ready again next cycle.
// A carriage return scans the line up to its end or its first zero byte, one byte per cycle,
// then sends one echo or reply character per cycle while tx is not stalled.
// A full line followed by another ordinary byte sends its 16-character notice from the next cycle on.
// Reset (rst_ni low, asynchronous) clears the state machine, line count and LEDs; buffer not cleared.
module serial_led_command_interpreter_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  output logic [7:0] tx_byte_o,
  output logic       last_of_run_o,
  output logic       led_one_on_o,
  output logic       led_two_on_o,
  output logic       tx_valid_o,
  input  logic       tx_stall_i
);
  import slci_pkg::*;

  slci_cmd_t  cmd;
  slci_stat_t stat;

  // Sequencer.
  slci_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .tx_valid_o (tx_valid_o),
    .tx_stall_i (tx_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Storage and text generation.
  slci_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_byte_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .tx_byte_o     (tx_byte_o),
    .last_of_run_o (last_of_run_o),
    .led_one_on_o  (led_one_on_o),
    .led_two_on_o  (led_two_on_o)
  );

`ifndef ASSERT_OFF
  // No input transaction is taken while characters are being sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni) tx_valid_o |-> rx_stall_o)
    else $error("input accepted while output active");

  // A line feed causes no output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_valid_i && !rx_stall_o && rx_byte_i == CH_LF) |=> !tx_valid_o)
    else $error("line feed produced output");

  // The final character of a run ends the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_valid_o && !tx_stall_i && last_of_run_o) |=> !tx_valid_o)
    else $error("output continued after last character");

  // LED outputs hold steady while a run is being sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_valid_o && $past(tx_valid_o)) |-> ($stable(led_one_on_o) && $stable(led_two_on_o)))
    else $error("LED state changed during a run");
`endif

endmodule
